// File: hw/rtl/cylinder_face_tessellator_assert.svh
// ----------------------------------------------------------------------------
// cylinder_face_tessellator_assert.svh
// assertion macros for the tessellator top module
// ----------------------------------------------------------------------------
`ifndef CYLINDER_FACE_TESSELLATOR_ASSERT_SVH
`define CYLINDER_FACE_TESSELLATOR_ASSERT_SVH
`ifndef SYNTH
// checked outside reset
`define CFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define CFT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CFT_ASSERT(lbl, prop, msg)
`define CFT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hw/rtl/ctf_pkg.sv
// ----------------------------------------------------------------------------
// ctf_pkg
// shared types, constants and helpers of the cylinder face tessellator
// ----------------------------------------------------------------------------
package ctf_pkg;

  localparam int MAX_FACES_DEF    = 64;
  localparam int SINE_ENTRIES_DEF = 1024;
  localparam int COORD_BITS_DEF   = 16;

  localparam int LANE_W = 16;
  localparam int PACK_W = 48;
  localparam int FC_W   = 7;
  localparam int IDX_W  = 3;
  localparam int ACC_W  = 40;
  localparam int TRIG_W = 19;
  localparam int T_W    = 20;
  localparam int ARG_W  = 17;

  localparam logic signed [23:0] COEF_A1 = 24'sd102944;
  localparam logic signed [23:0] COEF_A3 = -24'sd42334;
  localparam logic signed [23:0] COEF_A5 = 24'sd5233;
  localparam logic signed [23:0] COEF_A7 = -24'sd307;

  localparam logic [FC_W-1:0] FACE_COUNT_RST = 7'd30;

  typedef logic signed [LANE_W-1:0] coord_t;
  // x in the low lane, z in the high lane
  typedef coord_t [2:0] vec_t;

  typedef enum logic [IDX_W-1:0] {
    REG_CENTRE     = 3'd0,
    REG_RADIAL_A   = 3'd1,
    REG_RADIAL_B   = 3'd2,
    REG_AXIS       = 3'd3,
    REG_FACE_COUNT = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TRI_SIDE_LO = 2'd0,
    TRI_SIDE_HI = 2'd1,
    TRI_BOT_FAN = 2'd2,
    TRI_TOP_FAN = 2'd3
  } tri_kind_t;

  typedef struct packed {
    vec_t      a;
    vec_t      b;
    vec_t      c;
    tri_kind_t kind;
    logic      last;
  } tri_t;

  // q16 scale-down with truncation toward zero
  function automatic logic signed [23:0] q16_trunc(input logic signed [39:0] v);
    logic signed [39:0] b;
    b = v + (v[39] ? 40'sd65535 : 40'sd0);
    return 24'(b >>> 16);
  endfunction

endpackage

// File: hw/rtl/ctf_phase_div.sv
// ----------------------------------------------------------------------------
// ctf_phase_div
// pipelined restoring divider, one quotient bit per stage: k*entries/faces
// ----------------------------------------------------------------------------
module ctf_phase_div #(
  parameter int MAX_FACES    = ctf_pkg::MAX_FACES_DEF,
  parameter int SINE_ENTRIES = ctf_pkg::SINE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [$clog2(MAX_FACES+1)-1:0]  k,
  input  logic [$clog2(MAX_FACES+1)-1:0]  faces,
  output logic [$clog2(SINE_ENTRIES)-1:0] phase
);

  localparam int FW     = $clog2(MAX_FACES + 1);
  localparam int LOG_SE = $clog2(SINE_ENTRIES);
  localparam int QB     = LOG_SE + 1;

  logic [FW-1:0] rem_r [QB-1];
  logic [QB-1:0] quo_r [QB];

  for (genvar s = 0; s < QB; s++) begin : g_step
    logic [FW-1:0] rem_in;
    logic [QB-1:0] quo_in;
    logic          bit_in;
    logic [FW:0]   trial;
    logic          fits;

    // numerator is k followed by LOG_SE zeros; its top part k/2 is below faces
    if (s == 0) begin : g_first
      assign rem_in = k >> 1;
      assign quo_in = '0;
      assign bit_in = k[0];
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
      assign bit_in = 1'b0;
    end

    assign trial = {rem_in, bit_in};
    assign fits  = (trial >= {1'b0, faces});

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[s] <= {quo_in[QB-2:0], fits};
      end
    end

    if (s < QB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= fits ? FW'(trial - {1'b0, faces}) : FW'(trial);
        end
      end
    end
  end

  // quotient equals entries only for the closing face: wraps to zero
  assign phase = quo_r[QB-1][LOG_SE-1:0];

endmodule

// File: hw/rtl/ctf_sincos.sv
// ----------------------------------------------------------------------------
// ctf_sincos
// sine and cosine of a table phase by an odd quarter-wave polynomial
// ----------------------------------------------------------------------------
module ctf_sincos #(
  parameter int SINE_ENTRIES = ctf_pkg::SINE_ENTRIES_DEF
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [$clog2(SINE_ENTRIES)-1:0]        phase,
  output logic signed [ctf_pkg::TRIG_W-1:0]      sn,
  output logic signed [ctf_pkg::TRIG_W-1:0]      cs
);

  localparam int LOG_SE = $clog2(SINE_ENTRIES);
  localparam int AW     = ctf_pkg::ARG_W;
  localparam int TW     = ctf_pkg::T_W;
  localparam int FW     = ctf_pkg::TRIG_W;

  logic [1:0]              quad;
  logic [15:0]             frac;
  logic [AW-1:0]           arg_c [2];
  logic [AW-1:0]           x2_c  [2];
  logic [2*AW-1:0]         sq    [2];
  logic signed [39:0]      m0 [2];
  logic signed [39:0]      m1 [2];
  logic signed [39:0]      m2 [2];
  logic signed [39:0]      m3 [2];

  logic [AW-1:0]           arg_r [4][2];
  logic [AW-1:0]           x2_r  [3][2];
  logic signed [TW-1:0]    t_r   [3][2];
  logic signed [FW-1:0]    f_r   [2];
  logic [1:0]              q_r   [5];
  logic signed [FW-1:0]    sn_r;
  logic signed [FW-1:0]    cs_r;
  logic signed [FW-1:0]    sn_nxt;
  logic signed [FW-1:0]    cs_nxt;
  logic [1:0]              qc;

  // quadrant from the top phase bits, q16 fraction from the rest
  assign quad = phase[LOG_SE-1 -: 2];
  assign frac = 16'(phase[LOG_SE-3:0]) << (18 - LOG_SE);

  always_comb begin
    arg_c[0] = AW'(frac);
    arg_c[1] = AW'(17'd65536 - AW'(frac));
    for (int j = 0; j < 2; j++) begin
      sq[j]   = arg_c[j] * arg_c[j];
      x2_c[j] = sq[j][AW+15:16];
      m0[j]   = 40'(ctf_pkg::COEF_A7) * $signed({1'b0, x2_r[0][j]});
      m1[j]   = 40'(t_r[0][j]) * $signed({1'b0, x2_r[1][j]});
      m2[j]   = 40'(t_r[1][j]) * $signed({1'b0, x2_r[2][j]});
      m3[j]   = 40'(t_r[2][j]) * $signed({1'b0, arg_r[3][j]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r[0] <= quad;
      for (int s = 1; s < 5; s++) begin
        q_r[s] <= q_r[s-1];
      end
      for (int j = 0; j < 2; j++) begin
        arg_r[0][j] <= arg_c[j];
        arg_r[1][j] <= arg_r[0][j];
        arg_r[2][j] <= arg_r[1][j];
        arg_r[3][j] <= arg_r[2][j];
        x2_r[0][j]  <= x2_c[j];
        x2_r[1][j]  <= x2_r[0][j];
        x2_r[2][j]  <= x2_r[1][j];
        t_r[0][j]   <= TW'(ctf_pkg::COEF_A5 + ctf_pkg::q16_trunc(m0[j]));
        t_r[1][j]   <= TW'(ctf_pkg::COEF_A3 + ctf_pkg::q16_trunc(m1[j]));
        t_r[2][j]   <= TW'(ctf_pkg::COEF_A1 + ctf_pkg::q16_trunc(m2[j]));
        f_r[j]      <= FW'(ctf_pkg::q16_trunc(m3[j]));
      end
      sn_r <= sn_nxt;
      cs_r <= cs_nxt;
    end
  end

  // odd quadrants mirror the fraction, the upper half negates
  always_comb begin
    qc     = q_r[4] + 2'd1;
    sn_nxt = q_r[4][0] ? f_r[1] : f_r[0];
    if (q_r[4][1]) begin
      sn_nxt = -sn_nxt;
    end
    cs_nxt = qc[0] ? f_r[1] : f_r[0];
    if (qc[1]) begin
      cs_nxt = -cs_nxt;
    end
  end

  assign sn = sn_r;
  assign cs = cs_r;

endmodule

// File: hw/rtl/ctf_rim.sv
// ----------------------------------------------------------------------------
// ctf_rim
// bottom rim point: centre, half axis and the two scaled radius vectors
// ----------------------------------------------------------------------------
module ctf_rim (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [ctf_pkg::TRIG_W-1:0] sn,
  input  logic signed [ctf_pkg::TRIG_W-1:0] cs,
  input  ctf_pkg::vec_t                     centre,
  input  ctf_pkg::vec_t                     radial_a,
  input  ctf_pkg::vec_t                     radial_b,
  input  ctf_pkg::vec_t                     axis,
  output logic signed [ctf_pkg::ACC_W-1:0]  acc [3]
);

  localparam int AW = ctf_pkg::ACC_W;
  localparam int PW = ctf_pkg::TRIG_W + ctf_pkg::LANE_W;

  logic signed [PW-1:0] pa_r  [3];
  logic signed [PW-1:0] pb_r  [3];
  logic signed [AW-1:0] acc_r [3];
  logic signed [AW-1:0] sum_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_c[i] = (AW'($signed(centre[i])) <<< 17) - (AW'($signed(axis[i])) <<< 16)
               + (AW'(pa_r[i]) <<< 1) + (AW'(pb_r[i]) <<< 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa_r[i]  <= cs * $signed(radial_a[i]);
        pb_r[i]  <= sn * $signed(radial_b[i]);
        acc_r[i] <= sum_c[i];
      end
    end
  end

  assign acc = acc_r;

endmodule

// File: hw/rtl/ctf_emit.sv
// ----------------------------------------------------------------------------
// ctf_emit
// rounds the six vertices of a face and sends its four triangles in turn
// ----------------------------------------------------------------------------
module ctf_emit #(
  parameter int COORD_BITS = ctf_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  logic signed [ctf_pkg::ACC_W-1:0] v1 [3],
  input  logic signed [ctf_pkg::ACC_W-1:0] v2 [3],
  input  ctf_pkg::vec_t                    centre,
  input  ctf_pkg::vec_t                    axis,
  output logic                             take,
  output logic                             valid_o,
  output ctf_pkg::tri_t                    tri_o
);

  localparam int AW  = ctf_pkg::ACC_W;
  localparam int V_W = AW - 17;
  localparam logic signed [V_W-1:0] SAT_HI = V_W'((1 << (COORD_BITS - 1)) - 1);
  localparam logic signed [V_W-1:0] SAT_LO = V_W'(-(1 << (COORD_BITS - 1)));

  localparam int V1 = 0;
  localparam int V2 = 1;
  localparam int V3 = 2;
  localparam int V4 = 3;
  localparam int VB = 4;
  localparam int VT = 5;

  // round half up to q8.8, then clamp
  function automatic ctf_pkg::coord_t finish(input logic signed [AW-1:0] a);
    logic signed [AW-1:0]  t;
    logic signed [V_W-1:0] v;
    t = a + 40'sd65536;
    v = V_W'(t >>> 17);
    if (v > SAT_HI) begin
      v = SAT_HI;
    end else if (v < SAT_LO) begin
      v = SAT_LO;
    end
    return ctf_pkg::LANE_W'(v);
  endfunction

  ctf_pkg::vec_t        vtx_c [6];
  ctf_pkg::vec_t        vtx_r [6];
  logic signed [AW-1:0] ax17;
  logic signed [AW-1:0] ax16;
  logic signed [AW-1:0] c17;
  logic                 hold_v_r;
  ctf_pkg::tri_kind_t   cnt_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax17 = AW'($signed(axis[i])) <<< 17;
      ax16 = AW'($signed(axis[i])) <<< 16;
      c17  = AW'($signed(centre[i])) <<< 17;
      vtx_c[V1][i] = finish(v1[i]);
      vtx_c[V2][i] = finish(v2[i]);
      vtx_c[V3][i] = finish(v2[i] + ax17);
      vtx_c[V4][i] = finish(v1[i] + ax17);
      vtx_c[VB][i] = finish(c17 - ax16);
      vtx_c[VT][i] = finish(c17 + ax16);
    end
  end

  assign take = !hold_v_r || (cnt_r == ctf_pkg::TRI_TOP_FAN);

  always_ff @(posedge clk) begin
    if (load) begin
      vtx_r <= vtx_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      cnt_r    <= ctf_pkg::TRI_SIDE_LO;
    end else if (load) begin
      hold_v_r <= 1'b1;
      cnt_r    <= ctf_pkg::TRI_SIDE_LO;
    end else if (hold_v_r) begin
      hold_v_r <= (cnt_r != ctf_pkg::TRI_TOP_FAN);
      cnt_r    <= ctf_pkg::tri_kind_t'(cnt_r + 2'd1);
    end
  end

  always_comb begin
    tri_o.kind = cnt_r;
    tri_o.last = (cnt_r == ctf_pkg::TRI_TOP_FAN);
    case (cnt_r)
      ctf_pkg::TRI_SIDE_LO: begin
        tri_o.a = vtx_r[V1];
        tri_o.b = vtx_r[V2];
        tri_o.c = vtx_r[V3];
      end
      ctf_pkg::TRI_SIDE_HI: begin
        tri_o.a = vtx_r[V1];
        tri_o.b = vtx_r[V3];
        tri_o.c = vtx_r[V4];
      end
      ctf_pkg::TRI_BOT_FAN: begin
        tri_o.a = vtx_r[V2];
        tri_o.b = vtx_r[V1];
        tri_o.c = vtx_r[VB];
      end
      ctf_pkg::TRI_TOP_FAN: begin
        tri_o.a = vtx_r[V4];
        tri_o.b = vtx_r[V3];
        tri_o.c = vtx_r[VT];
      end
      default: begin
        tri_o.a = vtx_r[V1];
        tri_o.b = vtx_r[V2];
        tri_o.c = vtx_r[V3];
      end
    endcase
  end

  assign valid_o = hold_v_r;

endmodule

// File: hw/rtl/cylinder_face_tessellator.sv
// ----------------------------------------------------------------------------
// cylinder_face_tessellator
// one side face of a cylinder in, its four triangles out
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// input     in         start / busy          in_face_index
// result    out        out_valid strobe      vertices a, b, c, kind, last
// config    in         cfg_we                cfg_index, cfg_data
//
// each face gives its four triangles back to back on the single result port,
// which sets how often faces are taken; a face can enter while one is emitted.
// from transfer to first triangle a face passes the input stage, one divider
// stage per quotient bit, the sine and rim stages and the hold register.
// the pipeline halts as a whole while a finished face waits for the result
// port, which raises busy; the receiver cannot stall. reset clears valid bits.
// ----------------------------------------------------------------------------
`include "cylinder_face_tessellator_assert.svh"

module cylinder_face_tessellator #(
  parameter int MAX_FACES    = ctf_pkg::MAX_FACES_DEF,
  parameter int SINE_ENTRIES = ctf_pkg::SINE_ENTRIES_DEF,
  parameter int COORD_BITS   = ctf_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [ctf_pkg::FC_W-1:0]           in_face_index,
  input  logic                               cfg_we,
  input  logic [ctf_pkg::IDX_W-1:0]          cfg_index,
  input  logic [ctf_pkg::PACK_W-1:0]         cfg_data,
  output logic                               out_valid,
  output logic signed [ctf_pkg::LANE_W-1:0]  out_vertex_a_x,
  output logic signed [ctf_pkg::LANE_W-1:0]  out_vertex_a_y,
  output logic signed [ctf_pkg::LANE_W-1:0]  out_vertex_a_z,
  output logic signed [ctf_pkg::LANE_W-1:0]  out_vertex_b_x,
  output logic signed [ctf_pkg::LANE_W-1:0]  out_vertex_b_y,
  output logic signed [ctf_pkg::LANE_W-1:0]  out_vertex_b_z,
  output logic signed [ctf_pkg::LANE_W-1:0]  out_vertex_c_x,
  output logic signed [ctf_pkg::LANE_W-1:0]  out_vertex_c_y,
  output logic signed [ctf_pkg::LANE_W-1:0]  out_vertex_c_z,
  output logic [1:0]                         out_triangle_kind,
  output logic                               out_last_triangle
);

  localparam int FW     = $clog2(MAX_FACES + 1);
  localparam int CW     = (FW > ctf_pkg::FC_W) ? FW : ctf_pkg::FC_W;
  localparam int LOG_SE = $clog2(SINE_ENTRIES);
  localparam int LAT    = 1 + (LOG_SE + 1) + 6 + 2;

  ctf_pkg::vec_t            centre_r;
  ctf_pkg::vec_t            radial_a_r;
  ctf_pkg::vec_t            radial_b_r;
  ctf_pkg::vec_t            axis_r;
  logic [ctf_pkg::FC_W-1:0] face_count_r;

  logic [CW-1:0]            faces_w;
  logic [CW-1:0]            n_w;
  logic [FW-1:0]            faces_eff;
  logic [FW-1:0]            k1_r;
  logic [FW-1:0]            k2_r;
  logic [LAT-1:0]           vld_r;
  logic                     adv;
  logic                     load;
  logic                     emit_take;
  logic [LOG_SE-1:0]        ph1;
  logic [LOG_SE-1:0]        ph2;
  logic signed [ctf_pkg::TRIG_W-1:0] sn1, cs1, sn2, cs2;
  logic signed [ctf_pkg::ACC_W-1:0]  acc1 [3];
  logic signed [ctf_pkg::ACC_W-1:0]  acc2 [3];
  ctf_pkg::tri_t            tri_w;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_r     <= '0;
      radial_a_r   <= '0;
      radial_b_r   <= '0;
      axis_r       <= '0;
      face_count_r <= ctf_pkg::FACE_COUNT_RST;
    end else if (cfg_we) begin
      case (ctf_pkg::cfg_reg_t'(cfg_index))
        ctf_pkg::REG_CENTRE:     centre_r     <= cfg_data;
        ctf_pkg::REG_RADIAL_A:   radial_a_r   <= cfg_data;
        ctf_pkg::REG_RADIAL_B:   radial_b_r   <= cfg_data;
        ctf_pkg::REG_AXIS:       axis_r       <= cfg_data;
        ctf_pkg::REG_FACE_COUNT: face_count_r <= cfg_data[ctf_pkg::FC_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp face count and index into range
  always_comb begin
    faces_w = CW'(face_count_r);
    if (faces_w < CW'(3)) begin
      faces_w = CW'(3);
    end else if (faces_w > CW'(MAX_FACES)) begin
      faces_w = CW'(MAX_FACES);
    end
    n_w = CW'(in_face_index);
    if (n_w == '0) begin
      n_w = CW'(1);
    end else if (n_w > faces_w) begin
      n_w = faces_w;
    end
  end

  assign faces_eff = FW'(faces_w);

  // whole pipeline moves unless a finished face waits for the result port
  assign adv  = !vld_r[LAT-1] || emit_take;
  assign load = vld_r[LAT-1] && emit_take;
  assign busy = !adv;

  always_ff @(posedge clk) begin
    if (adv) begin
      k1_r <= FW'(n_w - CW'(1));
      k2_r <= FW'(n_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], start};
    end
  end

  ctf_phase_div #(.MAX_FACES(MAX_FACES), .SINE_ENTRIES(SINE_ENTRIES)) u_div1 (
    .clk(clk), .en(adv), .k(k1_r), .faces(faces_eff), .phase(ph1)
  );

  ctf_phase_div #(.MAX_FACES(MAX_FACES), .SINE_ENTRIES(SINE_ENTRIES)) u_div2 (
    .clk(clk), .en(adv), .k(k2_r), .faces(faces_eff), .phase(ph2)
  );

  ctf_sincos #(.SINE_ENTRIES(SINE_ENTRIES)) u_trig1 (
    .clk(clk), .en(adv), .phase(ph1), .sn(sn1), .cs(cs1)
  );

  ctf_sincos #(.SINE_ENTRIES(SINE_ENTRIES)) u_trig2 (
    .clk(clk), .en(adv), .phase(ph2), .sn(sn2), .cs(cs2)
  );

  ctf_rim u_rim1 (
    .clk(clk), .en(adv), .sn(sn1), .cs(cs1), .centre(centre_r),
    .radial_a(radial_a_r), .radial_b(radial_b_r), .axis(axis_r), .acc(acc1)
  );

  ctf_rim u_rim2 (
    .clk(clk), .en(adv), .sn(sn2), .cs(cs2), .centre(centre_r),
    .radial_a(radial_a_r), .radial_b(radial_b_r), .axis(axis_r), .acc(acc2)
  );

  ctf_emit #(.COORD_BITS(COORD_BITS)) u_emit (
    .clk(clk), .rst_n(rst_n), .load(load), .v1(acc1), .v2(acc2),
    .centre(centre_r), .axis(axis_r), .take(emit_take),
    .valid_o(out_valid), .tri_o(tri_w)
  );

  assign out_vertex_a_x    = tri_w.a[0];
  assign out_vertex_a_y    = tri_w.a[1];
  assign out_vertex_a_z    = tri_w.a[2];
  assign out_vertex_b_x    = tri_w.b[0];
  assign out_vertex_b_y    = tri_w.b[1];
  assign out_vertex_b_z    = tri_w.b[2];
  assign out_vertex_c_x    = tri_w.c[0];
  assign out_vertex_c_y    = tri_w.c[1];
  assign out_vertex_c_z    = tri_w.c[2];
  assign out_triangle_kind = tri_w.kind;
  assign out_last_triangle = tri_w.last;

  `CFT_ASSERT(a_accept_enters, start && !busy |=> vld_r[0], "accepted face not in pipeline")
  `CFT_ASSERT(a_beats_contiguous, out_valid && !out_last_triangle |=> out_valid, "face cut short")
  `CFT_ASSERT(a_last_is_top, out_valid |-> (out_last_triangle == (out_triangle_kind == ctf_pkg::TRI_TOP_FAN)), "last flag off top fan")
  `CFT_ASSERT(a_first_after_load, $past(load) |-> out_valid && out_triangle_kind == ctf_pkg::TRI_SIDE_LO, "face does not start at side lower")
  `CFT_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && vld_r == '0, "activity after reset")

endmodule
